### rtl/ser_pkg.sv
package ser_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int TRIG_W = 8;
	localparam int SCALE_W = 16;
	localparam int OFFSET_W = 16;
	localparam int DIST_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

	localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd2;
	localparam logic [SCALE_W-1:0] SCALE_Q16_RST = 16'd56230;
	localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd20;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	typedef struct packed {
		logic       busy;
		logic       trigger;
		logic [1:0] mux;
		logic       done;
		logic       timed_out;
		logic       measured;
	} ser_res_t;

	typedef struct packed {
		logic [TRIG_W-1:0]   trigger_ticks;
		logic [SCALE_W-1:0]  scale_q16;
		logic [OFFSET_W-1:0] offset;
	} ser_cfg_t;

endpackage

### rtl/sonar_echo_ranger.sv
// Ultrasonic echo range finder driven by one transaction per timer tick. Each
// accepted tick yields exactly one result showing busy, trigger level, mux lines
// and, on the tick a measurement ends, done with the distance
// (count * scale_q16 / 65536 - offset, clamped to 0..65535) or a timeout flag.
// A new tick is accepted every cycle while no result waits on out_ready. From the
// input register a tick passes registers for the state update, the
// count-times-scale multiplier and the offset subtract and clamp, and the whole
// pipeline stalls only while a result waits on out_ready. Configuration
// registers are written through the cfg port, which is always ready, and should
// only be changed while no tick is in flight.
module sonar_echo_ranger #(
	parameter int COUNT_BITS = ser_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ser_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ser_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           start_req,
	input  logic [2:0]                     sensor,
	input  logic                           echo,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           busy_res,
	output logic                           trigger_out,
	output logic [1:0]                     mux_select,
	output logic                           done_res,
	output logic [ser_pkg::DIST_W-1:0]     distance,
	output logic                           timed_out
);

	ser_pkg::ser_cfg_t     cfg;
	ser_pkg::ser_res_t     res_s2, res_q;
	logic [COUNT_BITS-1:0] count_s2;
	logic                  adv;
	logic                  valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                  start_s1, echo_s1;
	logic [2:0]            sensor_s1;

	assign cfg_ready = 1'b1;
	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign out_valid = out_valid_q;

	ser_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// all stages move together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_s1 <= start_req;
			sensor_s1 <= sensor;
			echo_s1 <= echo;
		end
	end

	ser_ctrl #(
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.item_en       (adv && valid_s1),
		.start_s1      (start_s1),
		.sensor_s1     (sensor_s1),
		.echo_s1       (echo_s1),
		.trigger_ticks (cfg.trigger_ticks),
		.res_s2        (res_s2),
		.count_s2      (count_s2)
	);

	ser_scale #(
		.COUNT_BITS (COUNT_BITS)
	) u_scale (
		.clk        (clk),
		.adv        (adv),
		.res_s2     (res_s2),
		.count_s2   (count_s2),
		.scale_q16  (cfg.scale_q16),
		.offset     (cfg.offset),
		.res_q      (res_q),
		.distance_q (distance)
	);

	assign busy_res = res_q.busy;
	assign trigger_out = res_q.trigger;
	assign mux_select = res_q.mux;
	assign done_res = res_q.done;
	assign timed_out = res_q.timed_out;

endmodule

### rtl/ser_cfg_regs.sv
module ser_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ser_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ser_pkg::CFG_DATA_W-1:0] wr_data,
	output ser_pkg::ser_cfg_t              cfg
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.trigger_ticks <= ser_pkg::TRIGGER_TICKS_RST;
			cfg.scale_q16 <= ser_pkg::SCALE_Q16_RST;
			cfg.offset <= ser_pkg::OFFSET_RST;
		end else if (wr_en) begin
			case (wr_index)
				ser_pkg::CFG_TRIGGER_TICKS: cfg.trigger_ticks <= wr_data[ser_pkg::TRIG_W-1:0];
				ser_pkg::CFG_SCALE_Q16: cfg.scale_q16 <= wr_data[ser_pkg::SCALE_W-1:0];
				ser_pkg::CFG_OFFSET: cfg.offset <= wr_data[ser_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/ser_ctrl.sv
module ser_ctrl #(
	parameter int COUNT_BITS = ser_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          item_en,
	input  logic                          start_s1,
	input  logic [2:0]                    sensor_s1,
	input  logic                          echo_s1,
	input  logic [ser_pkg::TRIG_W-1:0]    trigger_ticks,
	output ser_pkg::ser_res_t             res_s2,
	output logic [COUNT_BITS-1:0]         count_s2
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	ser_pkg::phase_t       phase_q, phase_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [1:0]            sel_q, sel_d;
	ser_pkg::ser_res_t     res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ser_pkg::PH_IDLE;
			count_q <= '0;
			sel_q <= '0;
		end else if (item_en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sel_q <= sel_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		sel_d = sel_q;
		res_d = '0;
		case (phase_q)
			ser_pkg::PH_IDLE: begin
				if (start_s1) begin
					if (sensor_s1[2]) begin
						res_d.done = 1'b1;
					end else begin
						sel_d = sensor_s1[1:0];
						phase_d = ser_pkg::PH_TRIG;
						count_d = COUNT_ONE;
					end
				end
			end
			ser_pkg::PH_TRIG: begin
				if (count_q < COUNT_BITS'(trigger_ticks)) begin
					count_d = count_q + COUNT_ONE;
				end else begin
					phase_d = ser_pkg::PH_WAIT;
					count_d = '0;
				end
			end
			ser_pkg::PH_WAIT: begin
				if (echo_s1) begin
					phase_d = ser_pkg::PH_MEAS;
					count_d = COUNT_ONE;
				end else if (count_q == COUNT_MAX) begin
					res_d.done = 1'b1;
					res_d.timed_out = 1'b1;
				end else begin
					count_d = count_q + COUNT_ONE;
				end
			end
			ser_pkg::PH_MEAS: begin
				if (!echo_s1) begin
					res_d.done = 1'b1;
					res_d.measured = 1'b1;
				end else if (count_q == COUNT_MAX) begin
					res_d.done = 1'b1;
					res_d.timed_out = 1'b1;
				end else begin
					count_d = count_q + COUNT_ONE;
				end
			end
			default: ;
		endcase
		if (res_d.done) begin
			phase_d = ser_pkg::PH_IDLE;
			count_d = '0;
		end
		res_d.busy = (phase_d != ser_pkg::PH_IDLE);
		res_d.trigger = (phase_d == ser_pkg::PH_TRIG);
		res_d.mux = sel_d;
	end

	// count before the clear feeds the distance stage
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
			count_s2 <= count_q;
		end
	end

endmodule

### rtl/ser_scale.sv
module ser_scale #(
	parameter int COUNT_BITS = ser_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           adv,
	input  ser_pkg::ser_res_t              res_s2,
	input  logic [COUNT_BITS-1:0]          count_s2,
	input  logic [ser_pkg::SCALE_W-1:0]    scale_q16,
	input  logic [ser_pkg::OFFSET_W-1:0]   offset,
	output ser_pkg::ser_res_t              res_q,
	output logic [ser_pkg::DIST_W-1:0]     distance_q
);

	localparam int PROD_W = COUNT_BITS + ser_pkg::SCALE_W;
	localparam int DW = (COUNT_BITS > ser_pkg::DIST_W) ? COUNT_BITS : ser_pkg::DIST_W;
	localparam logic [DW-1:0] DIST_MAX = DW'({ser_pkg::DIST_W{1'b1}});

	ser_pkg::ser_res_t     res_s3;
	logic [COUNT_BITS-1:0] scaled_s3;
	logic [PROD_W-1:0]     prod;
	logic [DW-1:0]         scaled_x, offset_x, diff;
	logic [ser_pkg::DIST_W-1:0] dist_d;

	assign prod = PROD_W'(count_s2) * PROD_W'(scale_q16);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res_s2;
			scaled_s3 <= prod[PROD_W-1:ser_pkg::SCALE_W];
		end
	end

	always_comb begin
		scaled_x = DW'(scaled_s3);
		offset_x = DW'(offset);
		diff = scaled_x - offset_x;
		if (!res_s3.measured || scaled_x <= offset_x) begin
			dist_d = '0;
		end else if (diff > DIST_MAX) begin
			dist_d = {ser_pkg::DIST_W{1'b1}};
		end else begin
			dist_d = diff[ser_pkg::DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_s3;
			distance_q <= dist_d;
		end
	end

endmodule

### bench/ranger_checker.sv
module ranger_checker #(
	parameter int COUNT_BITS = ser_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ser_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ser_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           start_req,
	input  logic [2:0]                     sensor,
	input  logic                           echo,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           busy_res,
	input  logic                           trigger_out,
	input  logic [1:0]                     mux_select,
	input  logic                           done_res,
	input  logic [ser_pkg::DIST_W-1:0]     distance,
	input  logic                           timed_out,
	output int                             errors,
	output int                             backlog,
	output logic                           ranger_idle,
	output logic                           ranger_waiting
);

	typedef struct packed {
		logic                       busy;
		logic                       trigger;
		logic [1:0]                 mux;
		logic                       done;
		logic [ser_pkg::DIST_W-1:0] dist_mm;
		logic                       tout;
	} reading_t;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	logic [ser_pkg::TRIG_W-1:0]   trig_len;
	logic [ser_pkg::SCALE_W-1:0]  scale;
	logic [ser_pkg::OFFSET_W-1:0] dist_offset;
	ser_pkg::phase_t              rng_phase;
	logic [COUNT_BITS-1:0]        rng_count;
	logic [1:0]                   rng_sensor;
	reading_t                     readings_q[$];

	// advance the ranger by one tick and queue the reading it shows
	task automatic ranger_tick(input logic go, input logic [2:0] sel, input logic lvl);
		reading_t          r;
		longint unsigned   scaled;
		r = '0;
		case (rng_phase)
			ser_pkg::PH_IDLE: begin
				if (go) begin
					if (sel > 3'd3) begin
						r.done = 1'b1;
					end else begin
						rng_sensor = sel[1:0];
						rng_phase = ser_pkg::PH_TRIG;
						rng_count = COUNT_ONE;
					end
				end
			end
			ser_pkg::PH_TRIG: begin
				// a trigger length of zero ends after the first tick, like one
				if (rng_count < trig_len) begin
					rng_count++;
				end else begin
					rng_phase = ser_pkg::PH_WAIT;
					rng_count = '0;
				end
			end
			ser_pkg::PH_WAIT: begin
				if (lvl) begin
					rng_phase = ser_pkg::PH_MEAS;
					rng_count = COUNT_ONE;
				end else if (rng_count == COUNT_TOP) begin
					r.done = 1'b1;
					r.tout = 1'b1;
				end else begin
					rng_count++;
				end
			end
			default: begin
				if (!lvl) begin
					r.done = 1'b1;
					scaled = rng_count;
					scaled = (scaled * scale) >> 16;
					if (scaled <= dist_offset)
						r.dist_mm = '0;
					else if (scaled - dist_offset > 65535)
						r.dist_mm = '1;
					else
						r.dist_mm = ser_pkg::DIST_W'(scaled - dist_offset);
				end else if (rng_count == COUNT_TOP) begin
					r.done = 1'b1;
					r.tout = 1'b1;
				end else begin
					rng_count++;
				end
			end
		endcase
		if (r.done) begin
			rng_phase = ser_pkg::PH_IDLE;
			rng_count = '0;
		end
		r.busy = (rng_phase != ser_pkg::PH_IDLE);
		r.trigger = (rng_phase == ser_pkg::PH_TRIG);
		r.mux = rng_sensor;
		readings_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		if (!arst_n) begin
			trig_len = ser_pkg::TRIGGER_TICKS_RST;
			scale = ser_pkg::SCALE_Q16_RST;
			dist_offset = ser_pkg::OFFSET_RST;
			rng_phase = ser_pkg::PH_IDLE;
			rng_count = '0;
			rng_sensor = 2'd0;
			readings_q.delete();
			errors = 0;
			backlog <= 0;
			ranger_idle <= 1'b1;
			ranger_waiting <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ser_pkg::CFG_TRIGGER_TICKS: trig_len = cfg_data[ser_pkg::TRIG_W-1:0];
					ser_pkg::CFG_SCALE_Q16:     scale = cfg_data[ser_pkg::SCALE_W-1:0];
					ser_pkg::CFG_OFFSET:        dist_offset = cfg_data[ser_pkg::OFFSET_W-1:0];
					default:                    ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {busy_res, trigger_out, mux_select, done_res, distance, timed_out};
				if (readings_q.size() == 0) begin
					errors++;
					$display("%0t: result transaction with nothing expected", $time);
				end else begin
					want = readings_q.pop_front();
					if (got !== want) begin
						errors++;
						$display({"%0t: mismatch expected busy=%0b trigger=%0b mux=%0d",
							" done=%0b distance=%0d timed_out=%0b, actual busy=%0b",
							" trigger=%0b mux=%0d done=%0b distance=%0d timed_out=%0b"},
							$time, want.busy, want.trigger, want.mux, want.done,
							want.dist_mm, want.tout, got.busy, got.trigger, got.mux,
							got.done, got.dist_mm, got.tout);
					end
				end
			end
			if (in_valid && in_ready)
				ranger_tick(start_req, sensor, echo);
			backlog <= readings_q.size();
			ranger_idle <= (rng_phase == ser_pkg::PH_IDLE);
			ranger_waiting <= (rng_phase == ser_pkg::PH_WAIT);
		end
	end

endmodule

### bench/testbench.sv
module testbench;

	localparam logic [ser_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [ser_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ser_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic                           start_req;
	logic [2:0]                     sensor;
	logic                           echo;
	logic                           out_valid;
	logic                           out_ready;
	logic                           busy_res;
	logic                           trigger_out;
	logic [1:0]                     mux_select;
	logic                           done_res;
	logic [ser_pkg::DIST_W-1:0]     distance;
	logic                           timed_out;

	int   errors;
	int   backlog;
	logic ranger_idle;
	logic ranger_waiting;
	logic calm;
	int   ticks_sent;
	int   trig_eff;

	sonar_echo_ranger u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .start_req(start_req),
		.sensor(sensor), .echo(echo),
		.out_valid(out_valid), .out_ready(out_ready), .busy_res(busy_res),
		.trigger_out(trigger_out), .mux_select(mux_select), .done_res(done_res),
		.distance(distance), .timed_out(timed_out)
	);

	ranger_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .start_req(start_req),
		.sensor(sensor), .echo(echo),
		.out_valid(out_valid), .out_ready(out_ready), .busy_res(busy_res),
		.trigger_out(trigger_out), .mux_select(mux_select), .done_res(done_res),
		.distance(distance), .timed_out(timed_out),
		.errors(errors), .backlog(backlog), .ranger_idle(ranger_idle),
		.ranger_waiting(ranger_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 37);
	end

	// one tick transaction; valid stays up afterwards unless the caller drops it
	task automatic push_tick(input logic go, input logic [2:0] sel, input logic lvl);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= go;
		sensor <= sel;
		echo <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// drain results and walk any open measurement back to idle
	task automatic settle();
		in_valid <= 1'b0;
		forever begin
			do @(posedge clk); while (backlog != 0);
			if (ranger_idle)
				break;
			push_tick(1'b0, 3'd0, ranger_waiting);
			in_valid <= 1'b0;
		end
	endtask

	task automatic write_reg(input logic [ser_pkg::CFG_IDX_W-1:0] idx,
			input logic [ser_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic reconfigure(input logic [7:0] trig, input logic [15:0] scl,
			input logic [15:0] off);
		settle();
		write_reg(ser_pkg::CFG_TRIGGER_TICKS, {8'($urandom), trig});
		write_reg(ser_pkg::CFG_SCALE_Q16, scl);
		write_reg(ser_pkg::CFG_OFFSET, off);
		write_reg(CFG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
		trig_eff = (trig == 8'd0) ? 1 : trig;
	endtask

	// mostly complete measurements with random content, some raw noise
	task automatic random_traffic(input int n);
		int stop_at;
		int w;
		int h;
		stop_at = ticks_sent + n;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(99) < 80) begin
				push_tick(1'b1, 3'($urandom_range(3)), 1'($urandom));
				repeat (trig_eff)
					push_tick(1'($urandom), 3'($urandom), 1'($urandom));
				w = $urandom_range(0, 12);
				h = ($urandom_range(99) < 10) ? $urandom_range(41, 400) : $urandom_range(1, 40);
				repeat (w)
					push_tick(1'($urandom), 3'($urandom), 1'b0);
				repeat (h)
					push_tick(1'($urandom), 3'($urandom), 1'b1);
				push_tick(1'($urandom), 3'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 6))
					push_tick(1'($urandom), 3'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		start_req = 1'b0;
		sensor = 3'd0;
		echo = 1'b0;
		out_ready = 1'b0;
		calm = 1'b0;
		ticks_sent = 0;
		trig_eff = ser_pkg::TRIGGER_TICKS_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out-of-range sensors answer at once
		push_tick(1'b1, 3'd7, 1'b0);
		push_tick(1'b1, 3'd4, 1'b1);
		// sensor 3, starts while busy are ignored, echo ignored during trigger
		push_tick(1'b1, 3'd3, 1'b1);
		push_tick(1'b1, 3'd1, 1'b1);
		push_tick(1'b0, 3'd0, 1'b1);
		push_tick(1'b1, 3'd2, 1'b0);
		push_tick(1'b0, 3'd0, 1'b1);
		push_tick(1'b1, 3'd5, 1'b1);
		push_tick(1'b0, 3'd0, 1'b1);
		push_tick(1'b0, 3'd0, 1'b0);
		// sensor 0, echo already high on the first waiting tick
		push_tick(1'b1, 3'd0, 1'b0);
		push_tick(1'b0, 3'd0, 1'b0);
		push_tick(1'b0, 3'd0, 1'b0);
		push_tick(1'b0, 3'd0, 1'b1);
		push_tick(1'b0, 3'd0, 1'b0);
		random_traffic(250);

		// no idling on either side
		reconfigure(8'd0, 16'hFFFF, 16'd0);
		calm <= 1'b1;
		random_traffic(250);
		calm <= 1'b0;

		reconfigure(8'd255, 16'd0, 16'hFFFF);
		random_traffic(400);

		repeat (4) begin
			reconfigure(8'($urandom_range(1, 40)), 16'($urandom), 16'($urandom_range(0, 30)));
			random_traffic(200);
		end

		settle();
		repeat (16) @(posedge clk);
		if (errors == 0 && backlog == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
rtl/ser_pkg.sv
rtl/ser_cfg_regs.sv
rtl/ser_ctrl.sv
rtl/ser_scale.sv
rtl/sonar_echo_ranger.sv
bench/ranger_checker.sv
bench/testbench.sv
